>>> rtl/core/assert_macros.svh
// Assertion macros shared by the checker modules of the core.
// Each macro takes a label, the clock, the active-low reset and the property terms.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/core/psf_pkg.sv
// Package of the shadow filter core: field widths, codes and reset values.
// Used by the top level and the checker; depends on nothing.
`timescale 1ns / 1ps
package psf_pkg;

    localparam int POS_W   = 12;
    localparam int DEPTH_W = 19;
    localparam int VIS_W   = 17;
    localparam int DIM_W   = 11;
    localparam int BIAS_W  = 16;
    localparam int LS_W    = 6;
    localparam int MR_W    = 3;
    localparam int FRAC_W  = 16;

    localparam logic [VIS_W-1:0] VIS_ONE = 17'h10000;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [2:0] {
        CFG_MAP_WIDTH  = 3'd0,
        CFG_MAP_HEIGHT = 3'd1,
        CFG_DEPTH_BIAS = 3'd2,
        CFG_LIGHT_SIZE = 3'd3,
        CFG_MAX_RADIUS = 3'd4
    } cfg_idx_t;

    localparam logic [DIM_W-1:0]  RST_MAP_WIDTH  = 11'd1024;
    localparam logic [DIM_W-1:0]  RST_MAP_HEIGHT = 11'd1024;
    localparam logic [BIAS_W-1:0] RST_DEPTH_BIAS = 16'd66;
    localparam logic [LS_W-1:0]   RST_LIGHT_SIZE = 6'd12;
    localparam logic [MR_W-1:0]   RST_MAX_RADIUS = 3'd6;

endpackage

>>> rtl/core/psf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for the shadow depth map.
`timescale 1ns / 1ps
module psf_ram #(
    parameter int WIDTH = 19,
    parameter int DEPTH = 1048576
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/psf_div.sv
// Restoring divider producing one quotient bit per cycle.
// Stand-alone; used by the top level for the visibility ratio.
`timescale 1ns / 1ps
module psf_div #(
    parameter int NUM_W = 25,
    parameter int DEN_W = 9
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] q_reg, q_next;
    logic [DEN_W-1:0] div_reg, div_next;
    logic [DEN_W:0]   trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        div_next  = div_reg;
        trial     = {rem_reg, q_reg[NUM_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            rem_next  = '0;
            q_next    = dividend;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = DEN_W'(trial - {1'b0, div_reg});
                q_next   = {q_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DEN_W-1:0];
                q_next   = {q_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

>>> rtl/core/pcss_shadow_filter_core.sv
// Top level of the percentage-closer soft shadow filter core.
// Depends on psf_pkg, psf_ram and psf_div.
`timescale 1ns / 1ps
// A write item passes through the states S_ADDR and S_WRITE. A query item visits each texel of the
// blocker search window and then, if blockers were found, each texel of the filter window, one texel
// at a time through the single read port of the depth map, in the states S_ADDR, S_READ and S_CMP
// for address, read and compare. Between the two windows the filter radius is set, by a radius step
// loop bounded by the capped max_radius, and the query closes with a division of the lit texel count
// by the filter texel count. A query that misses the map, or whose w_positive bit is clear, goes
// straight to the output. The input is held off while an item is in work, and the next item is taken
// while a finished result waits at the output.
module pcss_shadow_filter_core
    import psf_pkg::*;
#(
    parameter int MAP_SIDE          = 1024,
    parameter int SEARCH_RADIUS     = 2,
    parameter int MAX_FILTER_RADIUS = 6
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // pos_x[11:0], pos_y[23:12], depth[42:24], zero fill
    input  logic [1:0]  s_tuser,   // op[0], w_positive[1]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // visibility[16:0], blockers_found[17], in_map[18], zero fill
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int AW    = $clog2(MAP_SIDE * MAP_SIDE);
    localparam int DW    = $clog2(MAP_SIDE + 1);
    localparam int RMAX  = (SEARCH_RADIUS > MAX_FILTER_RADIUS) ? SEARCH_RADIUS
                                                               : MAX_FILTER_RADIUS;
    localparam int RW    = $clog2(RMAX + 1);
    localparam int OW    = RW + 1;
    localparam int NW    = $clog2((2 * SEARCH_RADIUS + 1) * (2 * SEARCH_RADIUS + 1) + 1);
    localparam int TW    = $clog2((2 * MAX_FILTER_RADIUS + 1) * (2 * MAX_FILTER_RADIUS + 1) + 1);
    localparam int CURW  = DEPTH_W + 1;
    localparam int CMPW  = DEPTH_W + 2;
    localparam int SUMW  = DEPTH_W + NW;
    localparam int DENW  = SUMW + 1;
    localparam int P1W   = CURW + NW + 1;
    localparam int NUMW  = P1W + LS_W + 1;
    localparam int DVW   = TW + FRAC_W;

    typedef enum logic [3:0] {
        S_IDLE, S_ADDR, S_WRITE, S_READ, S_CMP, S_MUL1, S_MUL2, S_RAD, S_DIV, S_DIVW, S_OUT
    } state_t;

    typedef enum logic [1:0] {PH_WRITE, PH_SEARCH, PH_FILTER} phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    logic [DIM_W-1:0]  map_width_reg, map_width_next;
    logic [DIM_W-1:0]  map_height_reg, map_height_next;
    logic [BIAS_W-1:0] bias_reg, bias_next;
    logic [LS_W-1:0]   ls_reg, ls_next;
    logic [MR_W-1:0]   mr_reg, mr_next;
    logic              mv_reg, mv_next;

    logic signed [POS_W-1:0]   px_reg, px_next, py_reg, py_next;
    logic signed [CURW-1:0]    cur_reg, cur_next;
    logic [DEPTH_W-1:0]        wd_reg, wd_next;
    logic signed [OW-1:0]      offx_reg, offx_next, offy_reg, offy_next;
    logic [RW-1:0]             rad_reg, rad_next, k_reg, k_next;
    logic signed [POS_W:0]     nx_reg, nx_next;
    logic                      hit_reg, hit_next;
    logic [AW-1:0]             row_reg, row_next;
    logic [NW-1:0]             n_reg, n_next;
    logic signed [SUMW-1:0]    sum_reg, sum_next;
    logic signed [P1W-1:0]     p1_reg, p1_next;
    logic signed [DENW-1:0]    den_reg, den_next;
    logic [NUMW-1:0]           num_reg, num_next, acc_reg, acc_next;
    logic [TW-1:0]             lit_reg, lit_next, tot_reg, tot_next;
    logic                      inmap_reg, inmap_next;
    logic [VIS_W-1:0]          pvis_reg, pvis_next, ovis_reg, ovis_next;
    logic                      pfound_reg, pfound_next, ofound_reg, ofound_next;
    logic                      oinmap_reg, oinmap_next;

    logic [DW-1:0]          eff_w, eff_h;
    logic [RW-1:0]          cap;
    logic signed [POS_W:0]  in_x, in_y, nx, ny;
    logic                   in_inside;
    logic [AW-1:0]          addr;
    logic [DEPTH_W-1:0]     rdata;
    logic signed [CMPW-1:0] sb;
    logic                   blocked;
    logic [NW-1:0]          n_upd;
    logic signed [NUMW-1:0] prod;
    logic                   last_tx;
    logic                   ram_we;
    logic                   div_start, div_done;
    logic [DVW-1:0]         quot;

    function automatic logic inside_map(logic signed [POS_W:0] x, logic signed [POS_W:0] y,
                                        logic [DW-1:0] w, logic [DW-1:0] h);
        return (x >= 0) && (x < $signed({1'b0, w})) && (y >= 0) && (y < $signed({1'b0, h}));
    endfunction

    assign eff_w = ({21'd0, map_width_reg} > 32'(MAP_SIDE)) ? DW'(MAP_SIDE) : DW'(map_width_reg);
    assign eff_h = ({21'd0, map_height_reg} > 32'(MAP_SIDE)) ? DW'(MAP_SIDE)
                                                            : DW'(map_height_reg);
    assign cap   = ({29'd0, mr_reg} > 32'(MAX_FILTER_RADIUS)) ? RW'(MAX_FILTER_RADIUS)
                                                             : RW'(mr_reg);

    assign in_x      = {s_tdata[11], s_tdata[11:0]};
    assign in_y      = {s_tdata[23], s_tdata[23:12]};
    assign in_inside = inside_map(in_x, in_y, eff_w, eff_h);
    assign nx        = {px_reg[POS_W-1], px_reg} + (POS_W+1)'(offx_reg);
    assign ny        = {py_reg[POS_W-1], py_reg} + (POS_W+1)'(offy_reg);
    assign addr      = row_reg + AW'(nx_reg[POS_W-1:0]);
    assign sb        = CMPW'($signed(rdata)) + $signed({{(CMPW-BIAS_W){1'b0}}, bias_reg});
    assign blocked   = CMPW'(cur_reg) > sb;
    assign n_upd     = (hit_reg && blocked) ? n_reg + 1'b1 : n_reg;
    assign prod      = NUMW'(p1_reg) * NUMW'($signed({1'b0, ls_reg}));
    assign last_tx   = (offx_reg == $signed({1'b0, rad_reg}))
                    && (offy_reg == $signed({1'b0, rad_reg}));
    assign ram_we    = (state_reg == S_WRITE) && hit_reg;
    assign div_start = (state_reg == S_DIV);

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = mv_reg;
    assign m_tdata   = {5'd0, oinmap_reg, ofound_reg, ovis_reg};

    psf_ram #(
        .WIDTH (DEPTH_W),
        .DEPTH (MAP_SIDE * MAP_SIDE)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr),
        .wdata (wd_reg),
        .raddr (addr),
        .rdata (rdata)
    );

    psf_div #(
        .NUM_W (DVW),
        .DEN_W (TW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (DVW'({lit_reg, {FRAC_W{1'b0}}}) + DVW'(tot_reg >> 1)),
        .divisor  (tot_reg),
        .done     (div_done),
        .quotient (quot)
    );

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        map_width_next  = map_width_reg;
        map_height_next = map_height_reg;
        bias_next       = bias_reg;
        ls_next         = ls_reg;
        mr_next         = mr_reg;
        mv_next         = mv_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        cur_next        = cur_reg;
        wd_next         = wd_reg;
        offx_next       = offx_reg;
        offy_next       = offy_reg;
        rad_next        = rad_reg;
        k_next          = k_reg;
        nx_next         = nx_reg;
        hit_next        = hit_reg;
        row_next        = row_reg;
        n_next          = n_reg;
        sum_next        = sum_reg;
        p1_next         = p1_reg;
        den_next        = den_reg;
        num_next        = num_reg;
        acc_next        = acc_reg;
        lit_next        = lit_reg;
        tot_next        = tot_reg;
        inmap_next      = inmap_reg;
        pvis_next       = pvis_reg;
        pfound_next     = pfound_reg;
        ovis_next       = ovis_reg;
        ofound_next     = ofound_reg;
        oinmap_next     = oinmap_reg;

        if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_MAP_WIDTH:  map_width_next  = cfg_data[DIM_W-1:0];
                CFG_MAP_HEIGHT: map_height_next = cfg_data[DIM_W-1:0];
                CFG_DEPTH_BIAS: bias_next       = cfg_data[BIAS_W-1:0];
                CFG_LIGHT_SIZE: ls_next         = cfg_data[LS_W-1:0];
                CFG_MAX_RADIUS: mr_next         = cfg_data[MR_W-1:0];
                default:        ;
            endcase
        end

        if (mv_reg && m_tready)
        begin
            mv_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    px_next    = s_tdata[11:0];
                    py_next    = s_tdata[23:12];
                    wd_next    = s_tdata[42:24];
                    cur_next   = CURW'($signed(s_tdata[42:24])) - CURW'(1 << FRAC_W);
                    inmap_next = in_inside;
                    if (s_tuser[0] == OP_WRITE)
                    begin
                        phase_next = PH_WRITE;
                        offx_next  = '0;
                        offy_next  = '0;
                        state_next = S_ADDR;
                    end
                    else if (in_inside && s_tuser[1])
                    begin
                        phase_next = PH_SEARCH;
                        rad_next   = RW'(SEARCH_RADIUS);
                        offx_next  = -OW'(SEARCH_RADIUS);
                        offy_next  = -OW'(SEARCH_RADIUS);
                        n_next     = '0;
                        sum_next   = '0;
                        state_next = S_ADDR;
                    end
                    else
                    begin
                        pvis_next   = VIS_ONE;
                        pfound_next = 1'b0;
                        state_next  = S_OUT;
                    end
                end
            end
            S_ADDR:
            begin
                nx_next    = nx;
                hit_next   = inside_map(nx, ny, eff_w, eff_h);
                row_next   = AW'(ny[POS_W-1:0]) * AW'(eff_w);
                state_next = (phase_reg == PH_WRITE) ? S_WRITE : S_READ;
            end
            S_WRITE:
            begin
                state_next = S_IDLE;
            end
            S_READ:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (phase_reg == PH_SEARCH)
                begin
                    n_next = n_upd;
                    if (hit_reg && blocked)
                    begin
                        sum_next = sum_reg + SUMW'($signed(rdata));
                    end
                end
                else if (hit_reg)
                begin
                    tot_next = tot_reg + 1'b1;
                    if (!blocked)
                    begin
                        lit_next = lit_reg + 1'b1;
                    end
                end
                if (offy_reg == $signed({1'b0, rad_reg}))
                begin
                    offy_next = -$signed({1'b0, rad_reg});
                    offx_next = offx_reg + 1'b1;
                end
                else
                begin
                    offy_next = offy_reg + 1'b1;
                end
                state_next = S_ADDR;
                if (last_tx)
                begin
                    if (phase_reg == PH_FILTER)
                    begin
                        state_next = S_DIV;
                    end
                    else if (n_upd == '0)
                    begin
                        pvis_next   = VIS_ONE;
                        pfound_next = 1'b0;
                        state_next  = S_OUT;
                    end
                    else
                    begin
                        state_next = S_MUL1;
                    end
                end
            end
            S_MUL1:
            begin
                den_next = DENW'(sum_reg) + $signed({1'b0, n_reg, {FRAC_W{1'b0}}});
                p1_next  = P1W'($signed({1'b0, n_reg})) * P1W'(cur_reg) - P1W'(sum_reg);
                if ((DENW'(sum_reg) + $signed({1'b0, n_reg, {FRAC_W{1'b0}}})) <= 0)
                begin
                    rad_next   = cap;
                    offx_next  = -$signed({1'b0, cap});
                    offy_next  = -$signed({1'b0, cap});
                    lit_next   = '0;
                    tot_next   = '0;
                    phase_next = PH_FILTER;
                    state_next = S_ADDR;
                end
                else
                begin
                    state_next = S_MUL2;
                end
            end
            S_MUL2:
            begin
                num_next   = prod[NUMW-1] ? '0 : NUMW'(prod);
                acc_next   = '0;
                k_next     = '0;
                state_next = S_RAD;
            end
            S_RAD:
            begin
                if ((k_reg < cap) && (acc_reg < num_reg))
                begin
                    acc_next = acc_reg + NUMW'(den_reg);
                    k_next   = k_reg + 1'b1;
                end
                else
                begin
                    rad_next   = k_reg;
                    offx_next  = -$signed({1'b0, k_reg});
                    offy_next  = -$signed({1'b0, k_reg});
                    lit_next   = '0;
                    tot_next   = '0;
                    phase_next = PH_FILTER;
                    state_next = S_ADDR;
                end
            end
            S_DIV:
            begin
                state_next = S_DIVW;
            end
            S_DIVW:
            begin
                if (div_done)
                begin
                    pvis_next   = quot[VIS_W-1:0];
                    pfound_next = 1'b1;
                    state_next  = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!mv_reg || m_tready)
                begin
                    mv_next     = 1'b1;
                    ovis_next   = pvis_reg;
                    ofound_next = pfound_reg;
                    oinmap_next = inmap_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            phase_reg      <= PH_WRITE;
            mv_reg         <= 1'b0;
            map_width_reg  <= RST_MAP_WIDTH;
            map_height_reg <= RST_MAP_HEIGHT;
            bias_reg       <= RST_DEPTH_BIAS;
            ls_reg         <= RST_LIGHT_SIZE;
            mr_reg         <= RST_MAX_RADIUS;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            mv_reg         <= mv_next;
            map_width_reg  <= map_width_next;
            map_height_reg <= map_height_next;
            bias_reg       <= bias_next;
            ls_reg         <= ls_next;
            mr_reg         <= mr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg     <= px_next;
        py_reg     <= py_next;
        cur_reg    <= cur_next;
        wd_reg     <= wd_next;
        offx_reg   <= offx_next;
        offy_reg   <= offy_next;
        rad_reg    <= rad_next;
        k_reg      <= k_next;
        nx_reg     <= nx_next;
        hit_reg    <= hit_next;
        row_reg    <= row_next;
        n_reg      <= n_next;
        sum_reg    <= sum_next;
        p1_reg     <= p1_next;
        den_reg    <= den_next;
        num_reg    <= num_next;
        acc_reg    <= acc_next;
        lit_reg    <= lit_next;
        tot_reg    <= tot_next;
        inmap_reg  <= inmap_next;
        pvis_reg   <= pvis_next;
        pfound_reg <= pfound_next;
        ovis_reg   <= ovis_next;
        ofound_reg <= ofound_next;
        oinmap_reg <= oinmap_next;
    end

endmodule

>>> rtl/core/psf_checker.sv
// Port-level checker for the shadow filter core, attached by bind.
// Depends on psf_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module psf_checker
    import psf_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    `ASSERT_NXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid)
    `ASSERT_NXT(a_out_stable, clk, rst_n, m_tvalid && !m_tready, $stable(m_tdata))
    `ASSERT_IMP(a_vis_range, clk, rst_n, m_tvalid, m_tdata[16:0] <= VIS_ONE)
    `ASSERT_IMP(a_unshadowed_lit, clk, rst_n, m_tvalid && !m_tdata[17], m_tdata[16:0] == VIS_ONE)

endmodule

bind pcss_shadow_filter_core psf_checker u_psf_checker (.*);
